FILE: design/frtm_pkg.sv
// Shared types and constants of the flow RTT and throughput monitor.
`timescale 1ns / 1ps

package frtm_pkg;

    // Item kinds carried in the mode field.
    localparam logic [1:0] MODE_ACK    = 2'd0;
    localparam logic [1:0] MODE_RATE   = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    localparam logic [15:0] SEG_SIZE_RESET = 16'd1460;
    localparam logic [19:0] US_IN_SECOND   = 20'd1000000;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] rtt_us;
        logic signed [31:0] delivered;
        logic signed [31:0] span_us;
        logic [31:0]        lost_packets;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] min_rtt_out;
        logic [31:0]        avg_rtt_out;
        logic [31:0]        rtt_samples_out;
        logic [39:0]        avg_rate_out;
        logic [31:0]        rate_samples_out;
        logic [31:0]        lost_bytes_out;
    } t_out_word;

    // One partial product request to the shared multiplier.
    typedef struct packed {
        logic        issue;
        logic        clear;
        logic        hi;
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    // Start request to the shared divider.
    typedef struct packed {
        logic        start;
        logic        long_op;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

endpackage

FILE: design/frtm_mul.sv
// Shared 32x32 multiplier with a registered product and a 64-bit accumulator.
`timescale 1ns / 1ps

module frtm_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frtm_pkg::t_mul_req i_req,
    output logic [63:0]        o_acc
);

    logic        r_p_vld;
    logic        r_p_clr;
    logic        r_p_hi;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] w_addend;
    logic [63:0] w_base;

    // A high partial product only contributes its low half, moved up by 32 bits.
    assign w_addend = r_p_hi ? {r_prod[31:0], 32'd0} : r_prod;
    assign w_base   = r_p_clr ? 64'd0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_p_clr <= 1'b0;
            r_p_hi  <= 1'b0;
        end else begin
            r_p_vld <= i_req.issue;
            r_p_clr <= i_req.clear;
            r_p_hi  <= i_req.hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.issue) begin
            r_prod <= i_req.a * i_req.b;
        end
        if (r_p_vld) begin
            r_acc <= w_base + w_addend;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: design/frtm_div.sv
// Shared restoring divider, one quotient bit per cycle, 32 or 64 quotient bits.
`timescale 1ns / 1ps

module frtm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frtm_pkg::t_div_req i_req,
    output logic               o_done,
    output logic [63:0]        o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_div;
    logic [32:0] w_rem_sh;
    logic [33:0] w_diff;
    logic        w_ge;

    // The remainder stays below the 32-bit divisor, so 33 bits hold the shifted value.
    // A zero divisor always passes the compare and yields an all-ones quotient.
    assign w_rem_sh = {r_rem, r_q[63]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_div};
    assign w_ge     = ~w_diff[33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.long_op ? 6'd63 : 6'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_q   <= i_req.long_op ? i_req.dividend : {i_req.dividend[31:0], 32'd0};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_rem_sh[31:0];
            r_q   <= {r_q[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: design/flow_rtt_throughput_monitor_core.sv
// Top level of the flow RTT and throughput monitor: sequencer and statistics state.
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_in_word  (t_in_word)
//  out      | output    | o_out_valid / i_out_stall | o_out_word (t_out_word)
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (segment size)
//
// An ignored word or an ack with zero RTT leaves the sequencer idle; an ack with positive
// RTT, a rate sample and a report occupy the sequencer, and the input stalls meanwhile.
// Acks and rate samples wait on the shared divider, one quotient bit per cycle.
// The result register frees the sequencer while a report word waits at a stalled output.
// Reset is synchronous: it clears all statistics and sets the segment size to 1460.
`timescale 1ns / 1ps

module flow_rtt_throughput_monitor_core #(
    parameter int RATE_FRACTION_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  frtm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output frtm_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_BW   = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_AVG  = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [2:0]          r_step;
    logic [2:0]          n_step;
    frtm_pkg::t_in_word  r_item;
    logic [15:0]         r_seg;
    logic [31:0]         r_min_rtt;
    logic [31:0]         r_rtt_avg;
    logic [31:0]         r_rtt_cnt;
    logic [63:0]         r_rate_avg;
    logic [31:0]         r_rate_cnt;
    logic [31:0]         r_lost_base;
    logic [63:0]         r_bw;
    logic [35:0]         r_k;
    logic [31:0]         r_lost_bytes;
    logic [39:0]         r_scaled;
    logic                r_out_vld;
    frtm_pkg::t_out_word r_out;

    frtm_pkg::t_mul_req  w_mul_req;
    frtm_pkg::t_div_req  w_div_req;
    logic [63:0]         w_acc;
    logic [63:0]         w_acc_sh;
    logic                w_div_done;
    logic [63:0]         w_quot;
    logic                w_accept;
    logic                w_rtt_ok;
    logic                w_rate_ok;
    logic                w_emit_ok;
    logic [31:0]         w_rtt_in;
    logic [31:0]         w_lost_diff;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_rtt_in    = i_in_word.rtt_us;
    assign w_rtt_ok    = !i_in_word.rtt_us[31];
    assign w_rate_ok   = !i_in_word.delivered[31] && !i_in_word.span_us[31]
                         && (i_in_word.span_us != 32'sd0);
    assign w_emit_ok   = !r_out_vld || !i_out_stall;
    assign w_lost_diff = r_item.lost_packets - r_lost_base;
    assign w_acc_sh    = w_acc >> RATE_FRACTION_BITS;

    frtm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_acc   (w_acc)
    );

    frtm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Partial products and divider starts by sequencer step. A product issued at a
    // step passes the product register and then the accumulator before a later step reads it.
    always_comb begin
        w_mul_req = '0;
        w_div_req = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in_word.mode == frtm_pkg::MODE_RATE) && w_rate_ok) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.long_op  = 1'b1;
                    w_div_req.dividend = {32'd0, i_in_word.delivered} << RATE_FRACTION_BITS;
                    w_div_req.divisor  = i_in_word.span_us;
                end
            end
            ST_MUL: begin
                if (r_item.mode == frtm_pkg::MODE_ACK) begin
                    if (r_step == 3'd0) begin
                        w_mul_req.issue = 1'b1;
                        w_mul_req.clear = 1'b1;
                        w_mul_req.a     = r_rtt_cnt;
                        w_mul_req.b     = r_rtt_avg;
                    end
                    if (r_step == 3'd2) begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = {32'd0, w_acc[31:0] + r_item.rtt_us};
                        w_div_req.divisor  = r_rtt_cnt + 32'd1;
                    end
                end else if (r_item.mode == frtm_pkg::MODE_RATE) begin
                    if (r_step == 3'd0 || r_step == 3'd1) begin
                        w_mul_req.issue = 1'b1;
                        w_mul_req.clear = (r_step == 3'd0);
                        w_mul_req.hi    = (r_step == 3'd1);
                        w_mul_req.a     = (r_step == 3'd0) ? r_rate_avg[31:0]
                                                           : r_rate_avg[63:32];
                        w_mul_req.b     = r_rate_cnt;
                    end
                    if (r_step == 3'd3) begin
                        w_div_req.start    = 1'b1;
                        w_div_req.long_op  = 1'b1;
                        w_div_req.dividend = w_acc + r_bw;
                        w_div_req.divisor  = r_rate_cnt + 32'd1;
                    end
                end else begin
                    // Report: segment scale, lost bytes, then the 64-bit scaled rate.
                    unique case (r_step)
                        3'd0: begin
                            w_mul_req.issue = 1'b1;
                            w_mul_req.clear = 1'b1;
                            w_mul_req.a     = {16'd0, r_seg};
                            w_mul_req.b     = {12'd0, frtm_pkg::US_IN_SECOND};
                        end
                        3'd1: begin
                            w_mul_req.issue = 1'b1;
                            w_mul_req.clear = 1'b1;
                            w_mul_req.a     = w_lost_diff;
                            w_mul_req.b     = {16'd0, r_seg};
                        end
                        3'd3: begin
                            w_mul_req.issue = 1'b1;
                            w_mul_req.clear = 1'b1;
                            w_mul_req.a     = r_rate_avg[31:0];
                            w_mul_req.b     = r_k[31:0];
                        end
                        3'd4: begin
                            w_mul_req.issue = 1'b1;
                            w_mul_req.hi    = 1'b1;
                            w_mul_req.a     = r_rate_avg[63:32];
                            w_mul_req.b     = r_k[31:0];
                        end
                        3'd5: begin
                            w_mul_req.issue = 1'b1;
                            w_mul_req.hi    = 1'b1;
                            w_mul_req.a     = r_rate_avg[31:0];
                            w_mul_req.b     = {28'd0, r_k[35:32]};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BW, ST_AVG, ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = 3'd0;
                if (w_accept) begin
                    priority if (i_in_word.mode == frtm_pkg::MODE_ACK) begin
                        if (w_rtt_ok && (w_rtt_in != 32'd0)) begin
                            n_state = ST_MUL;
                        end
                    end else if (i_in_word.mode == frtm_pkg::MODE_RATE) begin
                        if (w_rate_ok) begin
                            n_state = ST_BW;
                        end
                    end else if (i_in_word.mode == frtm_pkg::MODE_REPORT) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_BW: begin
                if (w_div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_step = r_step + 3'd1;
                priority if ((r_item.mode == frtm_pkg::MODE_ACK) && (r_step == 3'd2)) begin
                    n_state = ST_AVG;
                end else if ((r_item.mode == frtm_pkg::MODE_RATE) && (r_step == 3'd3)) begin
                    n_state = ST_AVG;
                end else if (r_step == 3'd7) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_AVG: begin
                if (w_div_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_emit_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 3'd0;
            r_seg       <= frtm_pkg::SEG_SIZE_RESET;
            r_min_rtt   <= '0;
            r_rtt_avg   <= '0;
            r_rtt_cnt   <= '0;
            r_rate_avg  <= '0;
            r_rate_cnt  <= '0;
            r_lost_base <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_valid) begin
                r_seg <= i_cfg_data;
            end
            if ((r_state == ST_EMIT) && w_emit_ok) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_in_word.mode == frtm_pkg::MODE_ACK) && w_rtt_ok) begin
                        if ((r_min_rtt == 32'd0) || (r_min_rtt > w_rtt_in)) begin
                            r_min_rtt <= w_rtt_in;
                        end
                    end
                end
                ST_AVG: begin
                    if (w_div_done) begin
                        if (r_item.mode == frtm_pkg::MODE_ACK) begin
                            r_rtt_avg <= w_quot[31:0];
                            r_rtt_cnt <= r_rtt_cnt + 32'd1;
                        end else begin
                            r_rate_avg <= w_quot;
                            r_rate_cnt <= r_rate_cnt + 32'd1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_emit_ok) begin
                        r_rtt_avg   <= '0;
                        r_rtt_cnt   <= '0;
                        r_rate_avg  <= '0;
                        r_rate_cnt  <= '0;
                        r_lost_base <= r_item.lost_packets;
                    end
                end
                ST_BW, ST_MUL: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_word;
        end
        if ((r_state == ST_BW) && w_div_done) begin
            r_bw <= w_quot;
        end
        if ((r_state == ST_MUL) && (r_item.mode == frtm_pkg::MODE_REPORT)) begin
            if (r_step == 3'd2) begin
                r_k <= w_acc[35:0];
            end
            if (r_step == 3'd3) begin
                r_lost_bytes <= w_acc[31:0];
            end
            if (r_step == 3'd7) begin
                r_scaled <= w_acc_sh[39:0];
            end
        end
        if ((r_state == ST_EMIT) && w_emit_ok) begin
            r_out.min_rtt_out      <= r_min_rtt;
            r_out.avg_rtt_out      <= r_rtt_avg;
            r_out.rtt_samples_out  <= r_rtt_cnt;
            r_out.avg_rate_out     <= r_scaled;
            r_out.rate_samples_out <= r_rate_cnt;
            r_out.lost_bytes_out   <= r_lost_bytes;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: design/frtm_checker.sv
// Port-level checks of the monitor core, bound to the top level.
`timescale 1ns / 1ps

module frtm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input frtm_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input frtm_pkg::t_out_word o_out_word
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // Reset leaves the block empty and ready for a word.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not empty after reset");

    // A pending result word holds while the output is stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word dropped or changed under stall");

    // Only a report word creates a result; other words never raise the output.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_word.mode != frtm_pkg::MODE_REPORT) && !o_out_valid)
        |=> !o_out_valid)
        else $error("result word without a report");

    // A report occupies the sequencer, so the next cycle stalls the input.
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_word.mode == frtm_pkg::MODE_REPORT)) |=> o_in_stall)
        else $error("input taken during a report");

endmodule

bind flow_rtt_throughput_monitor_core frtm_checker u_frtm_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench of the flow RTT and throughput monitor: queue-fed driver, shadow statistics, checker.
module testbench;
    import frtm_pkg::*;

    localparam int FRAC_BITS = 24;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CHUNK_WORDS = 140;
    localparam int DRAIN_CYCLES = 200;
    localparam int QUIET_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_word    in_word = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_stall;
    logic        out_valid;
    logic        cfg_ready;
    t_out_word   out_word;

    // Words waiting to be sent and reports the block still owes.
    t_in_word  send_q[$];
    t_out_word report_q[$];
    int        queued_words = 0;
    int        accepted_words = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    logic [31:0] lost_total = '0;

    // Shadow copy of the flow statistics and the segment size register.
    logic [31:0] sh_min_rtt = '0;
    logic [31:0] sh_rtt_avg = '0;
    logic [31:0] sh_rtt_cnt = '0;
    logic [63:0] sh_rate_avg = '0;
    logic [31:0] sh_rate_cnt = '0;
    logic [31:0] sh_lost_base = '0;
    logic [15:0] sh_seg = SEG_SIZE_RESET;

    flow_rtt_throughput_monitor_core #(
        .RATE_FRACTION_BITS(FRAC_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Folds one accepted word into the shadow statistics; a report word yields a result.
    task automatic track_word(input t_in_word w);
        logic [31:0] rtt;
        logic [31:0] sum;
        logic [31:0] lost_diff;
        logic [63:0] bw;
        logic [63:0] acc;
        logic [63:0] scaled;
        t_out_word   r;
        rtt = w.rtt_us;
        case (w.mode)
            MODE_ACK: begin
                if (!rtt[31]) begin
                    if (sh_min_rtt == 0 || sh_min_rtt > rtt) sh_min_rtt = rtt;
                    if (rtt != 0) begin
                        sum = sh_rtt_cnt * sh_rtt_avg + rtt;
                        sh_rtt_cnt = sh_rtt_cnt + 1;
                        sh_rtt_avg = (sh_rtt_cnt != 0) ? sum / sh_rtt_cnt : '1;
                    end
                end
            end
            MODE_RATE: begin
                if (!w.delivered[31] && !w.span_us[31] && w.span_us != 0) begin
                    bw = {32'b0, w.delivered} << FRAC_BITS;
                    bw = bw / {32'b0, w.span_us};
                    acc = sh_rate_avg * {32'b0, sh_rate_cnt} + bw;
                    sh_rate_cnt = sh_rate_cnt + 1;
                    sh_rate_avg = (sh_rate_cnt != 0) ? acc / {32'b0, sh_rate_cnt} : '1;
                end
            end
            MODE_REPORT: begin
                scaled = sh_rate_avg * {48'b0, sh_seg} * {44'b0, US_IN_SECOND};
                lost_diff = w.lost_packets - sh_lost_base;
                r.min_rtt_out = sh_min_rtt;
                r.avg_rtt_out = sh_rtt_avg;
                r.rtt_samples_out = sh_rtt_cnt;
                r.avg_rate_out = 40'(scaled >> FRAC_BITS);
                r.rate_samples_out = sh_rate_cnt;
                r.lost_bytes_out = lost_diff * {16'b0, sh_seg};
                report_q.push_back(r);
                sh_rtt_avg = '0;
                sh_rtt_cnt = '0;
                sh_rate_avg = '0;
                sh_rate_cnt = '0;
                sh_lost_base = w.lost_packets;
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            4: return 32'hffff_ffff;
            5: return $urandom_range(2000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word make_word(logic [1:0] mode, logic [31:0] rtt,
                                           logic [31:0] del, logic [31:0] itv,
                                           logic [31:0] lost);
        t_in_word w;
        w.mode = mode;
        w.rtt_us = rtt;
        w.delivered = del;
        w.span_us = itv;
        w.lost_packets = lost;
        return w;
    endfunction

    // Mostly well-formed samples with random content; the rest is noise.
    function automatic t_in_word random_word();
        t_in_word w;
        int sel;
        w = make_word(MODE_UNUSED, pick32(), pick32(), pick32(), pick32());
        sel = $urandom_range(99);
        if (sel < 45) begin
            w.mode = MODE_ACK;
            if ($urandom_range(9) < 7) begin
                w.rtt_us = ($urandom_range(2) == 0) ? ($urandom & 32'h7fff_ffff)
                                                    : $urandom_range(1, 400000);
            end
        end else if (sel < 80) begin
            w.mode = MODE_RATE;
            if ($urandom_range(3) != 0) begin
                w.delivered = ($urandom_range(3) == 0) ? ($urandom & 32'h7fff_ffff)
                                                       : $urandom_range(0, 200);
                w.span_us = ($urandom_range(5) == 0) ? ($urandom | 32'h1) & 32'h7fff_ffff
                                                     : $urandom_range(1, 2000000);
            end
        end else if (sel < 97) begin
            w.mode = MODE_REPORT;
            if ($urandom_range(99) < 85) begin
                lost_total = lost_total + $urandom_range(0, 40);
                w.lost_packets = lost_total;
            end
        end
        return w;
    endfunction

    // Input driver: a stalled word is held until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_word <= send_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    // Monitor: checks report words, then tracks accepted inputs and register writes.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (report_q.size() == 0) begin
                    $error("report word arrived with none expected");
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    check_field("min_rtt_out", want.min_rtt_out, out_word.min_rtt_out);
                    check_field("avg_rtt_out", want.avg_rtt_out, out_word.avg_rtt_out);
                    check_field("rtt_samples_out", want.rtt_samples_out,
                                out_word.rtt_samples_out);
                    check_field("avg_rate_out", want.avg_rate_out, out_word.avg_rate_out);
                    check_field("rate_samples_out", want.rate_samples_out,
                                out_word.rate_samples_out);
                    check_field("lost_bytes_out", want.lost_bytes_out, out_word.lost_bytes_out);
                end
            end
            if (in_valid && !in_stall) begin
                track_word(in_word);
                accepted_words++;
            end
            if (cfg_valid && cfg_ready) sh_seg = cfg_data;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("flow_rtt_throughput_monitor_core test failed");
            $finish;
        end
    end

    task automatic queue_word(input t_in_word w);
        send_q.push_back(w);
        queued_words++;
    endtask

    // Waits until every word is taken and every report is back, then lets the divider settle.
    task automatic drain();
        while (accepted_words != queued_words) @(posedge i_clk);
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] seg;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 14;
        stall_pct = 49;

        // Directed part at the reset segment size.
        queue_word(make_word(MODE_REPORT, 0, 0, 0, 0));
        queue_word(make_word(MODE_ACK, 32'hffff_ffff, 0, 0, 0));
        queue_word(make_word(MODE_ACK, 32'h8000_0000, 0, 0, 0));
        queue_word(make_word(MODE_ACK, 0, 0, 0, 0));
        queue_word(make_word(MODE_ACK, 100, 0, 0, 0));
        queue_word(make_word(MODE_ACK, 32'h7fff_ffff, 0, 0, 0));
        queue_word(make_word(MODE_ACK, 1, 0, 0, 0));
        queue_word(make_word(MODE_ACK, 0, 0, 0, 0));
        queue_word(make_word(MODE_ACK, 250, 0, 0, 0));
        queue_word(make_word(MODE_RATE, 0, 32'hffff_ffff, 10, 0));
        queue_word(make_word(MODE_RATE, 0, 5, 0, 0));
        queue_word(make_word(MODE_RATE, 0, 5, 32'h8000_0000, 0));
        queue_word(make_word(MODE_RATE, 0, 0, 1, 0));
        queue_word(make_word(MODE_RATE, 0, 32'h7fff_ffff, 1, 0));
        queue_word(make_word(MODE_RATE, 0, 1, 32'h7fff_ffff, 0));
        queue_word(make_word(MODE_UNUSED, '1, '1, '1, '1));
        queue_word(make_word(MODE_REPORT, 0, 0, 0, 32'hffff_ffff));
        queue_word(make_word(MODE_ACK, 50, 0, 0, 0));
        queue_word(make_word(MODE_RATE, 0, 10, 1000, 0));
        queue_word(make_word(MODE_REPORT, 0, 0, 0, 5));
        lost_total = 5;
        drain();

        for (int k = 0; k < 6; k++) begin
            if (k == 2) begin
                send_idle_pct = 49;
                stall_pct = 14;
            end else if (k == 4) begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            case (k)
                0: seg = 16'hffff;
                1: seg = 16'd1;
                2: seg = 16'd0;
                4: seg = SEG_SIZE_RESET;
                default: seg = 16'($urandom_range(1, 65535));
            endcase
            @(posedge i_clk);
            cfg_data <= seg;
            cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            for (int n = 0; n < CHUNK_WORDS; n++) queue_word(random_word());
            drain();
        end

        if (report_q.size() != 0) begin
            $error("%0d expected report words never arrived", report_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("flow_rtt_throughput_monitor_core test passed");
        end else begin
            $display("flow_rtt_throughput_monitor_core test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/frtm_pkg.sv
design/frtm_mul.sv
design/frtm_div.sv
design/flow_rtt_throughput_monitor_core.sv
design/frtm_checker.sv
tb/testbench.sv
